// File: src/fspa_pkg.sv
// Shared types, codes and defaults for the fixed slot pool allocator.
package fspa_pkg;

   // Default geometry of the pool.
   localparam int SLOT_COUNT_DEF = 8192;
   localparam int SLOT_BYTES_DEF = 128;

   // Reset values of the control registers.
   localparam logic [63:0] POOL_BASE_RST = 64'd0;
   localparam logic [31:0] MIN_REQ_RST   = 32'd0;
   localparam logic [31:0] MAX_REQ_RST   = 32'd128;

   // Request kinds.
   typedef enum logic [1:0] {
      KIND_ALLOC   = 2'd0,
      KIND_FREE    = 2'd1,
      KIND_REALLOC = 2'd2,
      KIND_SIZE    = 2'd3
   } kind_type;

   // Result actions.
   typedef enum logic [3:0] {
      ACT_GRANTED      = 4'd0,
      ACT_PASS_ALLOC   = 4'd1,
      ACT_FREED        = 4'd2,
      ACT_PASS_FREE    = 4'd3,
      ACT_KEPT         = 4'd4,
      ACT_MOVE_OUT     = 4'd5,
      ACT_PASS_REALLOC = 4'd6,
      ACT_SIZE         = 4'd7,
      ACT_PASS_SIZE    = 4'd8,
      ACT_ERROR        = 4'd9
   } action_type;

   // Control register indexes.
   typedef enum logic [1:0] {
      CSR_POOL_BASE = 2'd0,
      CSR_MIN_REQ   = 2'd1,
      CSR_MAX_REQ   = 2'd2
   } csr_reg_type;

   // Controller sequence.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CLASSIFY,
      ST_POP_MUL,
      ST_POP_ADD,
      ST_DIV_A,
      ST_DIV_B,
      ST_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;
      logic       pop;
      logic       push;
      logic       load_action;
      logic       load_alloc_addr;
      action_type action;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      kind_type kind;
      logic     in_pool;
      logic     win_ok;
      logic     fits;
      logic     empty;
      logic     full;
   } status_type;

endpackage

// File: src/fspa_ctrl.sv
// Controller state machine that sequences one request through the datapath.
module fspa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output logic                rsp_valid,
   input  fspa_pkg::status_type status,
   output fspa_pkg::cmd_type    cmd
);
   import fspa_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.action = ACT_ERROR;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_CLASSIFY;
         end
         ST_CLASSIFY: begin
            cmd.load_action = 1'b1;
            state_in        = ST_RESP;
            case (status.kind)
               KIND_ALLOC: begin
                  if (status.win_ok && !status.empty) begin
                     cmd.pop    = 1'b1;
                     cmd.action = ACT_GRANTED;
                     state_in   = ST_POP_MUL;
                  end else begin
                     cmd.action = ACT_PASS_ALLOC;
                  end
               end
               KIND_FREE: begin
                  if (!status.in_pool) begin
                     cmd.action = ACT_PASS_FREE;
                  end else if (status.full) begin
                     cmd.action = ACT_ERROR;
                  end else begin
                     cmd.action = ACT_FREED;
                     state_in   = ST_DIV_A;
                  end
               end
               KIND_REALLOC: begin
                  if (!status.in_pool) begin
                     cmd.action = ACT_PASS_REALLOC;
                  end else if (status.fits) begin
                     cmd.action = ACT_KEPT;
                  end else if (status.full) begin
                     cmd.action = ACT_ERROR;
                  end else begin
                     cmd.action = ACT_MOVE_OUT;
                     state_in   = ST_DIV_A;
                  end
               end
               KIND_SIZE: begin
                  cmd.action = status.in_pool ? ACT_SIZE : ACT_PASS_SIZE;
               end
               default: begin
                  cmd.action = ACT_ERROR;
               end
            endcase
         end
         ST_POP_MUL: begin
            state_in = ST_POP_ADD;
         end
         ST_POP_ADD: begin
            cmd.load_alloc_addr = 1'b1;
            state_in            = ST_RESP;
         end
         ST_DIV_A: begin
            state_in = ST_DIV_B;
         end
         ST_DIV_B: begin
            cmd.push = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: src/fspa_dp.sv
// Datapath: control registers, request decode, free-index stack and result registers.
module fspa_dp #(
   parameter int SLOT_COUNT = fspa_pkg::SLOT_COUNT_DEF,
   parameter int SLOT_BYTES = fspa_pkg::SLOT_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          req_kind,
   input  logic [31:0]         req_request_bytes,
   input  logic [63:0]         req_address,
   input  logic                csr_valid,
   input  logic [1:0]          csr_index,
   input  logic [63:0]         csr_wdata,
   input  fspa_pkg::cmd_type    cmd,
   output fspa_pkg::status_type status,
   output logic [3:0]          rsp_action,
   output logic [63:0]         rsp_result_address,
   output logic [15:0]         rsp_slot_bytes_out,
   output logic [15:0]         rsp_free_slots
);
   import fspa_pkg::*;

   // Geometry derived from the parameters.
   localparam longint unsigned SLOT_STRIDE = ((longint'(SLOT_BYTES) + 7) / 8) * 8;
   localparam longint unsigned POOL_SPAN = longint'(SLOT_COUNT) * SLOT_STRIDE;
   localparam int IDX_W  = $clog2(SLOT_COUNT);
   localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
   localparam int SZ_W   = $clog2(SLOT_STRIDE + 1);
   localparam int OFF_W  = $clog2(POOL_SPAN);
   localparam int MUL_W  = 2 * OFF_W;
   localparam int PROD_W = IDX_W + SZ_W;
   // Reciprocal of the slot size, scaled by two to the offset width.
   localparam longint unsigned RECIP = (64'd1 << OFF_W) / SLOT_STRIDE;

   // Control registers.
   logic [63:0] pool_base_ff;
   logic [31:0] min_req_ff;
   logic [31:0] max_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_base_ff <= POOL_BASE_RST;
         min_req_ff   <= MIN_REQ_RST;
         max_req_ff   <= MAX_REQ_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_POOL_BASE: pool_base_ff <= csr_wdata;
            CSR_MIN_REQ:   min_req_ff   <= csr_wdata[31:0];
            CSR_MAX_REQ:   max_req_ff   <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // Captured request beat.
   kind_type    kind_ff;
   logic [31:0] req_bytes_ff;
   logic [63:0] addr_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff      <= kind_type'(req_kind);
         req_bytes_ff <= req_request_bytes;
         addr_ff      <= req_address;
      end
   end

   // Decode stage: pool ownership, offset and size checks.
   logic [64:0]      diff;
   logic             in_pool_ff;
   logic             win_ok_ff;
   logic             fits_ff;
   logic [OFF_W-1:0] off_ff;

   assign diff = {1'b0, addr_ff} - {1'b0, pool_base_ff};

   always_ff @(posedge clock) begin
      in_pool_ff <= !diff[64] && (diff[63:0] < 64'(POOL_SPAN));
      off_ff     <= diff[OFF_W-1:0];
      win_ok_ff  <= (req_bytes_ff >= min_req_ff) && (req_bytes_ff <= max_req_ff);
      fits_ff    <= (req_bytes_ff <= 32'(SLOT_STRIDE));
   end

   // Slot index of the offset: reciprocal multiply, then one correction step.
   logic [MUL_W-1:0] recip_prod_ff;
   logic [OFF_W-1:0] q0_wide;
   logic [IDX_W-1:0] q0_ff;
   logic [OFF_W-1:0] q0d_ff;
   logic [OFF_W-1:0] rem;
   logic [IDX_W-1:0] push_idx;

   assign q0_wide = recip_prod_ff[MUL_W-1:OFF_W];

   always_ff @(posedge clock) begin
      recip_prod_ff <= MUL_W'(off_ff) * MUL_W'(RECIP);
      q0_ff         <= q0_wide[IDX_W-1:0];
      q0d_ff        <= OFF_W'(q0_wide[IDX_W-1:0]) * OFF_W'(SLOT_STRIDE);
   end

   assign rem      = off_ff - q0d_ff;
   assign push_idx = (rem >= OFF_W'(SLOT_STRIDE)) ? (q0_ff + IDX_W'(1)) : q0_ff;

   // Stack pointer and low-water mark. Entries from the lowest count reached
   // so far up to the pointer were written by a push; the entry just below
   // the mark still holds its reset value, which is its own position.
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] mark_ff;
   logic [CNT_W-1:0] cnt_dec;
   logic [IDX_W-1:0] pop_addr;
   logic             at_mark;

   assign cnt_dec  = count_ff - CNT_W'(1);
   assign pop_addr = cnt_dec[IDX_W-1:0];
   assign at_mark  = (count_ff == mark_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= CNT_W'(SLOT_COUNT);
         mark_ff  <= CNT_W'(SLOT_COUNT);
      end else if (cmd.pop) begin
         count_ff <= cnt_dec;
         if (at_mark) begin
            mark_ff <= cnt_dec;
         end
      end else if (cmd.push) begin
         count_ff <= count_ff + CNT_W'(1);
      end
   end

   // Free-index stack memory with registered read.
   logic [IDX_W-1:0] stack_mem [SLOT_COUNT];
   logic [IDX_W-1:0] rd_data_ff;
   logic             pop_init_ff;
   logic [IDX_W-1:0] pop_pos_ff;

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stack_mem[count_ff[IDX_W-1:0]] <= push_idx;
      end
      if (cmd.pop) begin
         rd_data_ff  <= stack_mem[pop_addr];
         pop_init_ff <= at_mark;
         pop_pos_ff  <= pop_addr;
      end
   end

   // Granted slot address: index times slot size, then add the base.
   logic [IDX_W-1:0]  pop_idx;
   logic [PROD_W-1:0] alloc_prod_ff;

   assign pop_idx = pop_init_ff ? pop_pos_ff : rd_data_ff;

   always_ff @(posedge clock) begin
      alloc_prod_ff <= PROD_W'(pop_idx) * PROD_W'(SLOT_STRIDE);
   end

   // Result registers.
   action_type  action_ff;
   logic [63:0] res_addr_ff;
   logic [15:0] bytes_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_action) begin
         action_ff   <= cmd.action;
         res_addr_ff <= (cmd.action == ACT_KEPT || cmd.action == ACT_MOVE_OUT) ?
                        addr_ff : 64'd0;
         bytes_ff    <= (cmd.action == ACT_SIZE || cmd.action == ACT_MOVE_OUT) ?
                        16'(SLOT_STRIDE) : 16'd0;
      end else if (cmd.load_alloc_addr) begin
         res_addr_ff <= pool_base_ff + 64'(alloc_prod_ff);
      end
   end

   assign rsp_action         = action_ff;
   assign rsp_result_address = res_addr_ff;
   assign rsp_slot_bytes_out = bytes_ff;
   assign rsp_free_slots     = 16'(count_ff);

   // Status toward the controller.
   assign status.kind    = kind_ff;
   assign status.in_pool = in_pool_ff;
   assign status.win_ok  = win_ok_ff;
   assign status.fits    = fits_ff;
   assign status.empty   = (count_ff == CNT_W'(0));
   assign status.full    = (count_ff == CNT_W'(SLOT_COUNT));

endmodule

// File: src/fixed_slot_pool_allocator_unit.sv
// Top level of the fixed slot pool allocator: controller plus datapath.
//
// Usage: a request beat (req_kind, req_request_bytes, req_address) is taken at
// a rising edge with start high and busy low. Exactly one result beat follows,
// shown on the rsp_ ports for one cycle while rsp_valid is high; the receiver
// must take it then, it cannot stall the block.
// Pass, kept, size and error results follow straight after the decode and
// classify steps; a granted allocate adds a registered stack read, an index
// multiply and a base add, and a free or move out adds a two-stage
// reciprocal multiply that turns the address offset into a slot index.
// busy drops in the cycle after the result; no new request is taken before.
// Control registers go through the csr_ write channel, which is always ready;
// write them only while the block is idle.
// Reset (synchronous, active high) restores the register defaults and marks
// every slot free. The stack memory is not swept: a low-water mark on the
// stack pointer tells which entries still hold their reset contents, so the
// block takes requests as soon as reset is released.
module fixed_slot_pool_allocator_unit #(
   parameter int SLOT_COUNT = fspa_pkg::SLOT_COUNT_DEF,
   parameter int SLOT_BYTES = fspa_pkg::SLOT_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_request_bytes,
   input  logic [63:0] req_address,
   output logic        rsp_valid,
   output logic [3:0]  rsp_action,
   output logic [63:0] rsp_result_address,
   output logic [15:0] rsp_slot_bytes_out,
   output logic [15:0] rsp_free_slots,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);
   import fspa_pkg::*;

   cmd_type    cmd;
   status_type status;

   // The register port never pushes back.
   assign csr_ready = 1'b1;

   fspa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   fspa_dp #(
      .SLOT_COUNT (SLOT_COUNT),
      .SLOT_BYTES (SLOT_BYTES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .req_kind           (req_kind),
      .req_request_bytes  (req_request_bytes),
      .req_address        (req_address),
      .csr_valid          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .cmd                (cmd),
      .status             (status),
      .rsp_action         (rsp_action),
      .rsp_result_address (rsp_result_address),
      .rsp_slot_bytes_out (rsp_slot_bytes_out),
      .rsp_free_slots     (rsp_free_slots)
   );

endmodule

// File: src/fspa_checker.sv
// Port-level checker for the fixed slot pool allocator and its bind.
module fspa_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [3:0]  rsp_action,
   input logic [63:0] rsp_result_address,
   input logic [15:0] rsp_slot_bytes_out,
   input logic [15:0] rsp_free_slots
);
   import fspa_pkg::*;

   // A result beat only appears while an item is in flight.
   a_rsp_in_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result beat outside an item");

   // After its result the block is free again.
   a_idle_after_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("block still busy after its result");

   // A granted slot carries no copy length.
   a_grant_no_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action == ACT_GRANTED) |-> (rsp_slot_bytes_out == 16'd0))
      else $error("granted result carries a length");

   // The free count only moves while an item is being worked on.
   a_count_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy && !start |=> $stable(rsp_free_slots))
      else $error("free count changed while idle");

   // Passed frees, passed size queries and kept results do not move the free count.
   a_pass_no_change: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action == ACT_PASS_FREE || rsp_action == ACT_KEPT ||
                    rsp_action == ACT_PASS_SIZE) |=> $stable(rsp_free_slots))
      else $error("free count moved on a result that changes nothing");

endmodule

bind fixed_slot_pool_allocator_unit fspa_checker u_fspa_checker (.*);

// File: dv/testbench.sv
// Self-checking testbench for the fixed slot pool allocator with a free-index stack.
`timescale 1ns / 1ps

module testbench;
   import fspa_pkg::*;

   // Pool geometry as the block is built with its default parameters.
   localparam logic [63:0] SLOT_STRIDE = 64'(((SLOT_BYTES_DEF + 7) / 8) * 8);
   localparam logic [63:0] POOL_SPAN = 64'(SLOT_COUNT_DEF) * SLOT_STRIDE;

   // One pending stimulus beat: either a request or a register write.
   typedef struct {
      logic        is_csr;
      csr_reg_type csr_idx;
      logic [63:0] csr_data;
      kind_type    kind;
      logic [31:0] bytes;
      logic [63:0] addr;
   } pool_op_type;

   // One predicted result beat.
   typedef struct packed {
      action_type  action;
      logic [63:0] address;
      logic [15:0] slot_bytes;
      logic [15:0] free_slots;
   } slot_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_kind = 2'd0;
   logic [31:0] req_request_bytes = 32'd0;
   logic [63:0] req_address = 64'd0;
   logic        rsp_valid;
   logic [3:0]  rsp_action;
   logic [63:0] rsp_result_address;
   logic [15:0] rsp_slot_bytes_out;
   logic [15:0] rsp_free_slots;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = 2'd0;
   logic [63:0] csr_wdata = 64'd0;

   // Stimulus and scoreboard storage.
   pool_op_type     pool_ops[$];
   slot_result_type pending_results[$];
   logic            req_fire = 1'b0;
   logic            csr_fire = 1'b0;
   int unsigned     mismatch_total = 0;
   int unsigned     cycle_count = 0;
   int unsigned     cycle_limit = 32'hFFFF_FFFF;
   int unsigned     burst_left = 1;
   int unsigned     gap_left = 0;

   // Predictor state: register copies, free-index stack and its fill level.
   logic [63:0] cfg_pool_base;
   logic [31:0] cfg_min_bytes;
   logic [31:0] cfg_max_bytes;
   logic [15:0] free_stack [SLOT_COUNT_DEF];
   int unsigned free_slot_count;

   fixed_slot_pool_allocator_unit dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_kind           (req_kind),
      .req_request_bytes  (req_request_bytes),
      .req_address        (req_address),
      .rsp_valid          (rsp_valid),
      .rsp_action         (rsp_action),
      .rsp_result_address (rsp_result_address),
      .rsp_slot_bytes_out (rsp_slot_bytes_out),
      .rsp_free_slots     (rsp_free_slots),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Works out the result of one request and updates the predicted stack.
   function automatic slot_result_type compute_slot_result(kind_type kind, logic [31:0] bytes,
                                                           logic [63:0] addr);
      slot_result_type r;
      logic [63:0]     offset;
      logic            owned;
      logic [15:0]     slot;
      offset = addr - cfg_pool_base;
      owned = (addr >= cfg_pool_base) && (offset < POOL_SPAN);
      slot = 16'(offset / SLOT_STRIDE);
      r.action = ACT_ERROR;
      r.address = 64'd0;
      r.slot_bytes = 16'd0;
      case (kind)
         KIND_ALLOC: begin
            if (bytes >= cfg_min_bytes && bytes <= cfg_max_bytes && free_slot_count > 0) begin
               free_slot_count--;
               r.address = cfg_pool_base
                         + 64'(free_stack[free_slot_count] % SLOT_COUNT_DEF) * SLOT_STRIDE;
               r.action = ACT_GRANTED;
            end else begin
               r.action = ACT_PASS_ALLOC;
            end
         end
         KIND_FREE: begin
            if (!owned) begin
               r.action = ACT_PASS_FREE;
            end else if (free_slot_count < SLOT_COUNT_DEF) begin
               free_stack[free_slot_count] = slot;
               free_slot_count++;
               r.action = ACT_FREED;
            end
         end
         KIND_REALLOC: begin
            if (!owned) begin
               r.action = ACT_PASS_REALLOC;
            end else if (64'(bytes) <= SLOT_STRIDE) begin
               r.action = ACT_KEPT;
               r.address = addr;
            end else if (free_slot_count < SLOT_COUNT_DEF) begin
               // Move out: the slot goes back on the stack in this same beat.
               free_stack[free_slot_count] = slot;
               free_slot_count++;
               r.action = ACT_MOVE_OUT;
               r.address = addr;
               r.slot_bytes = 16'(SLOT_STRIDE);
            end
         end
         default: begin
            if (owned) begin
               r.action = ACT_SIZE;
               r.slot_bytes = 16'(SLOT_STRIDE);
            end else begin
               r.action = ACT_PASS_SIZE;
            end
         end
      endcase
      r.free_slots = 16'(free_slot_count);
      return r;
   endfunction

   // Random request size, biased to the window edges and the slot size.
   function automatic logic [31:0] pick_bytes(logic [31:0] lo, logic [31:0] hi);
      case ($urandom_range(0, 6))
         0: return $urandom;
         1: return lo;
         2: return hi;
         3: return $urandom_range(32'(SLOT_STRIDE) - 32'd8, 32'(SLOT_STRIDE) + 32'd8);
         4: return $urandom_range(0, 1) ? lo - 1 : hi + 1;
         default: return (lo <= hi) ? $urandom_range(hi, lo) : $urandom;
      endcase
   endfunction

   // Random address, mostly inside the pool, with the pool edges and wild values mixed in.
   function automatic logic [63:0] pick_address(logic [63:0] base);
      case ($urandom_range(0, 9))
         0: return {$urandom, $urandom};
         1: return base - 1;
         2: return base + POOL_SPAN;
         3: return base + POOL_SPAN - 1;
         4: return base;
         default: return base + 64'($urandom_range(0, 32'(POOL_SPAN - 1)));
      endcase
   endfunction

   task automatic add_req(kind_type kind, logic [31:0] bytes, logic [63:0] addr);
      pool_op_type op;
      op.is_csr = 1'b0;
      op.csr_idx = CSR_POOL_BASE;
      op.csr_data = 64'd0;
      op.kind = kind;
      op.bytes = bytes;
      op.addr = addr;
      pool_ops.push_back(op);
   endtask

   task automatic add_csr(csr_reg_type idx, logic [63:0] data);
      pool_op_type op;
      op.is_csr = 1'b1;
      op.csr_idx = idx;
      op.csr_data = data;
      op.kind = KIND_ALLOC;
      op.bytes = 32'd0;
      op.addr = 64'd0;
      pool_ops.push_back(op);
   endtask

   task automatic set_pool(logic [63:0] base, logic [31:0] lo, logic [31:0] hi);
      add_csr(CSR_POOL_BASE, base);
      add_csr(CSR_MIN_REQ, {32'd0, lo});
      add_csr(CSR_MAX_REQ, {32'd0, hi});
   endtask

   // Mixed traffic: allocations and frees keep the stack moving, queries in between.
   task automatic add_random_ops(int count, logic [63:0] base, logic [31:0] lo, logic [31:0] hi);
      int unsigned roll;
      repeat (count) begin
         roll = $urandom_range(0, 99);
         if (roll < 35)
            add_req(KIND_ALLOC, pick_bytes(lo, hi), pick_address(base));
         else if (roll < 65)
            add_req(KIND_FREE, pick_bytes(lo, hi), pick_address(base));
         else if (roll < 85)
            add_req(KIND_REALLOC, pick_bytes(lo, hi), pick_address(base));
         else
            add_req(KIND_SIZE, pick_bytes(lo, hi), pick_address(base));
      end
   endtask

   // Driver: new beats go out on the falling edge and are held until taken.
   always @(negedge clock) begin
      pool_op_type op;
      logic        drive_req;
      logic        drive_csr;
      drive_req = 1'b0;
      drive_csr = 1'b0;
      if (reset) begin
         burst_left = $urandom_range(1, 24);
         gap_left = 0;
      end else if ((start && !req_fire) || (csr_valid && !csr_fire)) begin
         drive_req = start;
         drive_csr = csr_valid;
      end else if (pool_ops.size() != 0) begin
         if (pool_ops[0].is_csr) begin
            // Registers change only once the block has drained.
            if (pending_results.size() == 0 && !busy) begin
               op = pool_ops.pop_front();
               csr_index <= op.csr_idx;
               csr_wdata <= op.csr_data;
               drive_csr = 1'b1;
            end
         end else if (gap_left != 0) begin
            gap_left--;
         end else begin
            op = pool_ops.pop_front();
            req_kind <= op.kind;
            req_request_bytes <= op.bytes;
            req_address <= op.addr;
            drive_req = 1'b1;
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
         end
      end
      start <= drive_req;
      csr_valid <= drive_csr;
   end

   // Monitor: checks result beats, tracks register writes and predicts accepted requests.
   always @(posedge clock) begin
      slot_result_type want;
      int              i;
      if (reset) begin
         cfg_pool_base = POOL_BASE_RST;
         cfg_min_bytes = MIN_REQ_RST;
         cfg_max_bytes = MAX_REQ_RST;
         for (i = 0; i < SLOT_COUNT_DEF; i++)
            free_stack[i] = 16'(i);
         free_slot_count = SLOT_COUNT_DEF;
         req_fire <= 1'b0;
         csr_fire <= 1'b0;
      end else begin
         req_fire <= start && !busy;
         csr_fire <= csr_valid && csr_ready;
         if (rsp_valid) begin
            if (pending_results.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= 10)
                  $display("unexpected result beat: action %0d address %h",
                           rsp_action, rsp_result_address);
            end else begin
               want = pending_results.pop_front();
               if (rsp_action !== want.action || rsp_result_address !== want.address ||
                   rsp_slot_bytes_out !== want.slot_bytes ||
                   rsp_free_slots !== want.free_slots) begin
                  mismatch_total++;
                  if (mismatch_total <= 10) begin
                     $write("mismatch: action %0d/%0d address %h/%h ",
                            want.action, rsp_action, want.address, rsp_result_address);
                     $display("slot bytes %0d/%0d free slots %0d/%0d (expected/actual)",
                              want.slot_bytes, rsp_slot_bytes_out,
                              want.free_slots, rsp_free_slots);
                  end
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_reg_type'(csr_index))
               CSR_POOL_BASE: cfg_pool_base = csr_wdata;
               CSR_MIN_REQ:   cfg_min_bytes = csr_wdata[31:0];
               CSR_MAX_REQ:   cfg_max_bytes = csr_wdata[31:0];
               default: ;
            endcase
         end
         if (start && !busy)
            pending_results.push_back(compute_slot_result(kind_type'(req_kind),
                                                          req_request_bytes, req_address));
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > cycle_limit) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   initial begin
      logic [63:0] base;

      // Directed part at reset settings: base 0, window 0 to 128, stack full.
      add_req(KIND_FREE,    32'd0,          64'h0);        // free with full stack
      add_req(KIND_REALLOC, 32'd129,        64'h80);       // move out with full stack
      add_req(KIND_REALLOC, 32'd128,        64'h0);        // fits exactly
      add_req(KIND_REALLOC, 32'd0,          POOL_SPAN - 1);
      add_req(KIND_SIZE,    32'd0,          64'h0);
      add_req(KIND_SIZE,    32'hFFFF_FFFF,  POOL_SPAN);    // first byte past the pool
      add_req(KIND_SIZE,    32'd0,          '1);
      add_req(KIND_ALLOC,   32'd0,          64'h0);        // window low edge
      add_req(KIND_ALLOC,   32'd128,        '1);           // window high edge
      add_req(KIND_ALLOC,   32'd129,        64'h0);
      add_req(KIND_ALLOC,   32'hFFFF_FFFF,  64'h0);
      add_req(KIND_FREE,    32'd0,          POOL_SPAN - 59); // address inside a slot
      add_req(KIND_FREE,    32'd0,          64'h10);       // slot that was never taken
      add_req(KIND_FREE,    32'd0,          64'h10);       // stack full again
      add_req(KIND_ALLOC,   32'd64,         64'h0);
      add_req(KIND_ALLOC,   32'd1,          64'h0);
      add_req(KIND_FREE,    32'd0,          64'h20);
      add_req(KIND_FREE,    32'd0,          64'h20);       // double free while room is left
      add_req(KIND_ALLOC,   32'd5,          64'h0);
      add_req(KIND_REALLOC, 32'hFFFF_FFFF,  64'h7F);       // move out with room
      add_req(KIND_REALLOC, 32'd0,          POOL_SPAN);
      add_req(KIND_FREE,    32'd0,          POOL_SPAN);
      add_req(KIND_FREE,    32'hFFFF_FFFF,  '1);
      add_req(KIND_ALLOC,   32'd0,          64'h0);
      add_random_ops(120, POOL_BASE_RST, MIN_REQ_RST, MAX_REQ_RST);

      // Random base with a narrow window around the slot size.
      base = {$urandom, $urandom};
      set_pool(base, 32'd40, 32'd300);
      add_random_ops(100, base, 32'd40, 32'd300);

      // Pool at the very top of the address space; only the largest size is in the window.
      base = 64'hFFFF_FFFF_FFFF_FFFF - POOL_SPAN + 1;
      set_pool(base, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_random_ops(80, base, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

      // Empty window: every allocate passes on.
      set_pool(64'd0, 32'hFFFF_FFFF, 32'd0);
      add_random_ops(60, 64'd0, 32'hFFFF_FFFF, 32'd0);

      // Random base with the widest window, so every allocate is served while a slot is free.
      base = {$urandom, $urandom};
      set_pool(base, 32'd0, 32'hFFFF_FFFF);
      add_random_ops(120, base, 32'd0, 32'hFFFF_FFFF);

      // Base at all ones: only that single address lies in the pool.
      set_pool('1, 32'd0, 32'd0);
      add_random_ops(70, '1, 32'd0, 32'd0);

      cycle_limit = 40 * pool_ops.size() + 20000;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pool_ops.size() != 0 || pending_results.size() != 0 || start || csr_valid)
         @(posedge clock);
      repeat (12) @(posedge clock);

      if (mismatch_total == 0 && pending_results.size() == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
